// ===== sv/cctt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Class chain tail tracker package
// Shared types, operation codes and the class weight table.
// ----------------------------------------------------------------------------
package cctt_pkg;

	// Operation codes carried on the func port.
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// Number of entries in the weight table; larger classes use the last one.
	localparam int unsigned WEIGHT_ENTRIES = 7;
	localparam int unsigned WEIGHT_BITS    = 9;

	// Command qualifiers handed to every cell of the row.
	typedef struct packed {
		logic fire;    // an item is accepted in this cycle
		logic is_add;  // the item adds a stream, otherwise it removes one
	} cell_ctl_t;

	// Flags that travel from a cell toward the lower classes.
	typedef struct packed {
		logic has_tail;  // some class at or above this one holds a tail
		logic par_hit;   // some such tail equals the removed stream's parent
	} cell_link_t;

	// Fixed dependency weight for each class index.
	function automatic logic [WEIGHT_BITS-1:0] class_weight(input logic [2:0] idx);
		logic [WEIGHT_BITS-1:0] w;
		w = 9'd256;
		case (idx)
			3'd0:    w = 9'd37;
			3'd1:    w = 9'd74;
			3'd2:    w = 9'd110;
			3'd3:    w = 9'd147;
			3'd4:    w = 9'd183;
			3'd5:    w = 9'd220;
			default: w = 9'd256;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cctt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Class chain tail tracker cell
// Holds the tail slot of one class and passes search results to neighbors.
// ----------------------------------------------------------------------------
module cctt_cell #(
	parameter int unsigned K        = 0,
	parameter int unsigned ID_BITS  = 16,
	parameter int unsigned CLS_BITS = 3
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire cctt_pkg::cell_ctl_t  ctl,
	input  wire  [CLS_BITS-1:0]     cls,
	input  wire  [ID_BITS-1:0]      sid,
	input  wire  [ID_BITS-1:0]      parent,
	input  wire                     root_hit,
	// from the next higher class
	input  wire cctt_pkg::cell_link_t up_in,
	input  wire  [ID_BITS-1:0]      up_tail_in,
	// from the next lower class
	input  wire                     found_in,
	// toward the next lower class
	output cctt_pkg::cell_link_t    up_out,
	output logic [ID_BITS-1:0]      up_tail_out,
	// toward the next higher class
	output logic                    found_out
);

	logic               valid_q;
	logic [ID_BITS-1:0] tail_q;
	logic               sid_match;
	logic               par_match;
	logic               rem_hit;
	logic               add_here;
	logic               do_clear;

	assign sid_match = valid_q && (tail_q == sid);
	assign par_match = valid_q && (tail_q == parent);

	// The first matching class, counted from the lowest, owns the remove.
	assign rem_hit   = sid_match && !found_in;
	assign found_out = found_in || sid_match;

	assign up_out.has_tail = valid_q || up_in.has_tail;
	assign up_out.par_hit  = par_match || up_in.par_hit;
	assign up_tail_out     = valid_q ? tail_q : up_tail_in;

	assign add_here = ctl.fire && ctl.is_add && (32'(cls) == K);
	assign do_clear = up_out.par_hit || root_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (add_here) begin
			valid_q <= 1'b1;
		end else if (ctl.fire && !ctl.is_add && rem_hit && do_clear) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (add_here) begin
			tail_q <= sid;
		end else if (ctl.fire && !ctl.is_add && rem_hit && !do_clear) begin
			tail_q <= parent;
		end
	end

endmodule
`default_nettype wire

// ===== sv/class_chain_tail_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Class chain tail tracker
// Tracks the tail stream of each priority class in an exclusive chain.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. The
// result of an item accepted at one rising edge is on the result ports during
// the following cycle, marked by done, for that single cycle only; the
// receiver cannot hold it off, so it must capture it then. In the row of
// class cells the search for the nearest occupied class and the remove
// match ripple through the row within the cycle in which the item is
// accepted, and the cells and the result registers update at its end. The
// root_id register may be written at any edge while no item is in flight.
// ----------------------------------------------------------------------------
module class_chain_tail_tracker #(
	parameter int unsigned NUM_CLASSES = 7,
	parameter int unsigned ID_BITS     = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// command side
	input  wire         start,
	output logic        busy,
	input  wire         func,
	input  wire  [15:0] stream_id,
	input  wire  [2:0]  traffic_class,
	input  wire  [15:0] current_parent,
	// configuration
	input  wire         root_id_we,
	input  wire  [15:0] root_id,
	// result side
	output logic        done,
	output logic [15:0] parent_node,
	output logic        parent_is_root,
	output logic [8:0]  weight,
	output logic        exclusive_dep,
	output logic        was_tail
);

	localparam int unsigned CLS_BITS = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	cctt_pkg::cell_ctl_t  ctl;
	logic                 accept;
	logic [CLS_BITS-1:0]  cls_sat;
	logic [2:0]           widx;
	logic [ID_BITS-1:0]   sid;
	logic [ID_BITS-1:0]   cur_par;
	logic [ID_BITS-1:0]   root_q;
	logic [31:0]          sid_ext;
	logic [31:0]          par_ext;
	logic [31:0]          root_ext;
	logic [31:0]          pick_ext;
	logic                 root_hit;
	logic [ID_BITS-1:0]   pick_id;
	logic                 pick_has;

	// Chain wiring: link/tail arrays carry cell k's output toward class k-1,
	// found carries cell k's output toward class k+1.
	cctt_pkg::cell_link_t link_out [NUM_CLASSES];
	logic [ID_BITS-1:0]   tail_out [NUM_CLASSES];
	logic                 found_out [NUM_CLASSES];

	// The block finishes an item in the cycle it is accepted.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign ctl.fire   = accept;
	assign ctl.is_add = (func == cctt_pkg::FUNC_ADD);

	// Identifiers are reduced to ID_BITS before any storage or comparison.
	assign sid_ext  = 32'(stream_id);
	assign par_ext  = 32'(current_parent);
	assign sid      = sid_ext[ID_BITS-1:0];
	assign cur_par  = par_ext[ID_BITS-1:0];
	assign root_hit = (cur_par == root_q);

	// Classes beyond the last one fold onto the last one; weight indexes
	// beyond the table fold onto its last entry.
	always_comb begin
		if (32'(traffic_class) >= NUM_CLASSES) begin
			cls_sat = CLS_BITS'(NUM_CLASSES - 1);
		end else begin
			cls_sat = CLS_BITS'(traffic_class);
		end
		if (32'(cls_sat) >= cctt_pkg::WEIGHT_ENTRIES - 1) begin
			widx = 3'(cctt_pkg::WEIGHT_ENTRIES - 1);
		end else begin
			widx = 3'(cls_sat);
		end
	end

	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cell
		cctt_pkg::cell_link_t up_in;
		logic [ID_BITS-1:0]   up_tail_in;
		logic                 found_in;

		if (k == NUM_CLASSES - 1) begin : g_top
			assign up_in      = '0;
			assign up_tail_in = '0;
		end else begin : g_mid
			assign up_in      = link_out[k+1];
			assign up_tail_in = tail_out[k+1];
		end

		if (k == 0) begin : g_bot
			assign found_in = 1'b0;
		end else begin : g_low
			assign found_in = found_out[k-1];
		end

		cctt_cell #(
			.K        (k),
			.ID_BITS  (ID_BITS),
			.CLS_BITS (CLS_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cls         (cls_sat),
			.sid         (sid),
			.parent      (cur_par),
			.root_hit    (root_hit),
			.up_in       (up_in),
			.up_tail_in  (up_tail_in),
			.found_in    (found_in),
			.up_out      (link_out[k]),
			.up_tail_out (tail_out[k]),
			.found_out   (found_out[k])
		);
	end

	// The cell at the item's class sees the nearest occupied class at or
	// above it; when none is occupied the root is the parent.
	assign pick_has = link_out[cls_sat].has_tail;
	assign pick_id  = pick_has ? tail_out[cls_sat] : root_q;
	assign pick_ext = 32'(pick_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (root_id_we) begin
			root_q <= root_ext[ID_BITS-1:0];
		end
	end

	assign root_ext = 32'(root_id);

	// Result registers. Fields that do not apply to the operation read zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done           <= 1'b0;
			parent_node    <= '0;
			parent_is_root <= 1'b0;
			weight         <= '0;
			exclusive_dep  <= 1'b0;
			was_tail       <= 1'b0;
		end else begin
			done <= accept;
			if (accept) begin
				if (ctl.is_add) begin
					parent_node    <= pick_ext[15:0];
					parent_is_root <= !pick_has;
					weight         <= cctt_pkg::class_weight(widx);
					exclusive_dep  <= 1'b1;
					was_tail       <= 1'b0;
				end else begin
					parent_node    <= '0;
					parent_is_root <= 1'b0;
					weight         <= '0;
					exclusive_dep  <= 1'b0;
					was_tail       <= found_out[NUM_CLASSES-1];
				end
			end
		end
	end

	// Every accepted item yields exactly one result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted item");

	// An add result never reports a removed tail, and its weight is in range.
	a_add_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && exclusive_dep) |-> (!was_tail && weight >= 9'd37 && weight <= 9'd256))
		else $error("add result fields inconsistent");

	// A remove result carries only the was_tail flag.
	a_rem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !exclusive_dep) |-> (parent_node == 16'd0 && weight == 9'd0
			&& !parent_is_root))
		else $error("remove result carries add fields");

endmodule
`default_nettype wire

// ===== tb/cctt_chain_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Class chain tail tracker checker
// Watches the command, configuration and result ports. It keeps its own copy
// of the per-class tails and of the root id, predicts the result of every
// accepted item, and compares each strobed result, field by field, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module cctt_chain_checker #(
	parameter int unsigned NUM_CLASSES = 7
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire        busy,
	input  wire        func,
	input  wire [15:0] stream_id,
	input  wire [2:0]  traffic_class,
	input  wire [15:0] current_parent,
	input  wire        root_id_we,
	input  wire [15:0] root_id,
	input  wire        done,
	input  wire [15:0] parent_node,
	input  wire        parent_is_root,
	input  wire [8:0]  weight,
	input  wire        exclusive_dep,
	input  wire        was_tail,
	output int         pending,
	output int         mismatches
);

	typedef struct packed {
		logic [15:0] parent_node;
		logic        parent_is_root;
		logic [8:0]  weight;
		logic        exclusive_dep;
		logic        was_tail;
	} chain_result_t;

	// Class weights, class 0 in the low nine bits.
	localparam logic [cctt_pkg::WEIGHT_ENTRIES*cctt_pkg::WEIGHT_BITS-1:0] WEIGHT_TABLE =
		{9'd256, 9'd220, 9'd183, 9'd147, 9'd110, 9'd74, 9'd37};

	logic [15:0]   tail_id   [NUM_CLASSES];
	logic          tail_live [NUM_CLASSES];
	logic [15:0]   root_copy;
	chain_result_t awaited_results [$];

	// Applies one item to the tail copy and returns the result it must give.
	function automatic chain_result_t track_tails(input logic op, input logic [15:0] sid,
			input logic [2:0] tcls, input logic [15:0] par);
		chain_result_t r;
		int            cls;
		int            widx;
		int            hit;
		logic          found;
		logic          clear;
		r = '0;
		if (op == cctt_pkg::FUNC_ADD) begin
			cls  = (tcls >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(tcls);
			widx = (cls < cctt_pkg::WEIGHT_ENTRIES) ? cls : cctt_pkg::WEIGHT_ENTRIES - 1;
			r.parent_node    = root_copy;
			r.parent_is_root = 1'b1;
			found = 1'b0;
			for (int k = cls; k < NUM_CLASSES; k++) begin
				if (!found && tail_live[k]) begin
					found            = 1'b1;
					r.parent_node    = tail_id[k];
					r.parent_is_root = 1'b0;
				end
			end
			r.weight        = WEIGHT_TABLE[widx*cctt_pkg::WEIGHT_BITS +: cctt_pkg::WEIGHT_BITS];
			r.exclusive_dep = 1'b1;
			tail_id[cls]    = sid;
			tail_live[cls]  = 1'b1;
		end else begin
			hit = -1;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				if (hit < 0 && tail_live[k] && tail_id[k] == sid)
					hit = k;
			end
			if (hit >= 0) begin
				// The slot empties when the parent already sits at this class or
				// above, or is the root; otherwise the parent takes over the slot.
				clear = (par == root_copy);
				for (int j = hit; j < NUM_CLASSES; j++) begin
					if (tail_live[j] && tail_id[j] == par)
						clear = 1'b1;
				end
				if (clear)
					tail_live[hit] = 1'b0;
				else
					tail_id[hit] = par;
				r.was_tail = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		chain_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				tail_id[k]   = '0;
				tail_live[k] = 1'b0;
			end
			root_copy = '0;
			awaited_results.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			// The result of an older item is retired before a new item is added.
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item outstanding: parent_node %0h, was_tail %0b",
						parent_node, was_tail);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("parent_node", want.parent_node, parent_node);
					check_field("parent_is_root", 16'(want.parent_is_root), 16'(parent_is_root));
					check_field("weight", 16'(want.weight), 16'(weight));
					check_field("exclusive_dep", 16'(want.exclusive_dep), 16'(exclusive_dep));
					check_field("was_tail", 16'(want.was_tail), 16'(was_tail));
				end
			end
			if (root_id_we)
				root_copy = root_id;
			if (start && !busy)
				awaited_results.push_back(track_tails(func, stream_id, traffic_class,
					current_parent));
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_class_chain_tail_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Class chain tail tracker testbench
// Drives add and remove items into the tracker, first a directed walk through
// the chain rules and then random phases under several root ids, while a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_class_chain_tail_tracker;

	localparam int NUM_PHASES      = 6;
	localparam int PHASE_ITEMS     = 300;
	localparam int POOL_SIZE       = 10;
	// Even with the longest idle gap after every item the run needs well under
	// 50 us, so this only trips when the block hangs or drops results.
	localparam int TIMEOUT_NS      = 400_000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [15:0] stream_id;
	logic [2:0]  traffic_class;
	logic [15:0] current_parent;
	logic        root_id_we;
	logic [15:0] root_id;
	logic        done;
	logic [15:0] parent_node;
	logic        parent_is_root;
	logic [8:0]  weight;
	logic        exclusive_dep;
	logic        was_tail;

	int          pending_items;
	int          fail_count;

	// Root id of the current phase and a small set of stream ids. Drawing most
	// ids from the set makes removes find real tails and parents match tails,
	// which is where the interesting slot updates happen.
	logic [15:0] root_now;
	logic [15:0] id_pool [POOL_SIZE];

	class_chain_tail_tracker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.stream_id      (stream_id),
		.traffic_class  (traffic_class),
		.current_parent (current_parent),
		.root_id_we     (root_id_we),
		.root_id        (root_id),
		.done           (done),
		.parent_node    (parent_node),
		.parent_is_root (parent_is_root),
		.weight         (weight),
		.exclusive_dep  (exclusive_dep),
		.was_tail       (was_tail)
	);

	cctt_chain_checker chain_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.stream_id      (stream_id),
		.traffic_class  (traffic_class),
		.current_parent (current_parent),
		.root_id_we     (root_id_we),
		.root_id        (root_id),
		.done           (done),
		.parent_node    (parent_node),
		.parent_is_root (parent_is_root),
		.weight         (weight),
		.exclusive_dep  (exclusive_dep),
		.was_tail       (was_tail),
		.pending        (pending_items),
		.mismatches     (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Presents one item at the falling edge and returns once it has been taken
	// at a rising edge. start is left high so that back-to-back items keep it
	// asserted without a low pulse in between; the next call or a pause decides
	// what happens at the following falling edge.
	task automatic issue_item(input logic op, input logic [15:0] sid, input logic [2:0] cls,
			input logic [15:0] par);
		@(negedge clk);
		start          <= 1'b1;
		func           <= op;
		stream_id      <= sid;
		traffic_class  <= cls;
		current_parent <= par;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Holds start low for the given number of cycles.
	task automatic pause_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// The root id is only changed once the block is idle: start is lowered,
	// every outstanding result is collected, and start is held low once more
	// before the one-cycle write pulse.
	task automatic write_root(input logic [15:0] value);
		pause_input(1);
		while (pending_items != 0)
			@(negedge clk);
		pause_input(2);
		@(negedge clk);
		root_id_we <= 1'b1;
		root_id    <= value;
		@(negedge clk);
		root_id_we <= 1'b0;
		root_now = value;
	endtask

	// Mostly well-formed traffic on the id set, with a share of ids equal to the
	// root and of fully random ids as noise. Class 7 lies beyond the last class
	// and must behave like the highest one.
	task automatic issue_random_item();
		logic        op;
		logic [15:0] sid;
		logic [15:0] par;
		int          pick;
		op   = ($urandom_range(0, 99) < 45) ? cctt_pkg::FUNC_REMOVE : cctt_pkg::FUNC_ADD;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			sid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (pick == 8)
			sid = root_now;
		else
			sid = 16'($urandom);
		pick = $urandom_range(0, 19);
		if (pick < 6)
			par = root_now;
		else if (pick < 17)
			par = id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			par = 16'($urandom);
		issue_item(op, sid, 3'($urandom_range(0, 7)), par);
	endtask

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic gaps_on;
		logic [15:0] next_root;
		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		func           = cctt_pkg::FUNC_ADD;
		stream_id      = '0;
		traffic_class  = '0;
		current_parent = '0;
		root_id_we     = 1'b0;
		root_id        = '0;
		root_now       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed walk with the root at zero. Comments give the parent or the
		// slot change that each item should produce.
		write_root(16'h0000);
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h1234, 3'd0, 16'h0000); // nothing tracked
		issue_item(cctt_pkg::FUNC_ADD, 16'h0000, 3'd0, 16'hFFFF);    // root parent, lowest weight
		issue_item(cctt_pkg::FUNC_ADD, 16'hFFFF, 3'd6, 16'h0000);    // root parent, top weight
		issue_item(cctt_pkg::FUNC_ADD, 16'h0101, 3'd7, 16'h5A5A);    // class past the end acts as 6
		issue_item(cctt_pkg::FUNC_ADD, 16'h0202, 3'd3, 16'h0000);    // parent found in class 6
		issue_item(cctt_pkg::FUNC_ADD, 16'h0303, 3'd1, 16'h0000);    // parent is the class 3 tail
		issue_item(cctt_pkg::FUNC_ADD, 16'h0202, 3'd5, 16'h0000);    // already a tail, added again
		issue_item(cctt_pkg::FUNC_ADD, 16'h0404, 3'd2, 16'h0000);
		issue_item(cctt_pkg::FUNC_ADD, 16'h0505, 3'd4, 16'h0000);
		pause_input(3);
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0303, 3'd0, 16'h0404); // parent tails a higher class
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0404, 3'd0, 16'h0777); // untracked parent takes slot
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0777, 3'd0, 16'h0777); // parent equal to the stream
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0505, 3'd0, 16'h0000); // parent is the root
		issue_item(cctt_pkg::FUNC_ADD, 16'h0606, 3'd1, 16'h0000);
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0202, 3'd7, 16'hFFFF); // first matching class is 3
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0101, 3'd0, 16'h8000);
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0606, 3'd0, 16'h0000); // tail of class 0 lies below
		issue_item(cctt_pkg::FUNC_ADD, 16'hAAAA, 3'd2, 16'h0000);
		issue_item(cctt_pkg::FUNC_ADD, 16'h5555, 3'd5, 16'h0000);
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h0000, 3'd0, 16'h0000); // matches own slot, clears
		issue_item(cctt_pkg::FUNC_REMOVE, 16'h9999, 3'd6, 16'hFFFF); // unknown stream, no change

		// Random phases, each under its own root id with a fresh id set. Idle
		// gaps come and go in stretches of forty items; the last phase runs
		// with start held high throughout.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       next_root = 16'hFFFF;
				2:       next_root = 16'h0000;
				default: next_root = 16'($urandom);
			endcase
			write_root(next_root);
			for (int k = 0; k < POOL_SIZE; k++)
				id_pool[k] = 16'($urandom);
			gaps_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
				issue_random_item();
				if (gaps_on && $urandom_range(0, 3) == 0)
					pause_input($urandom_range(1, 5));
			end
		end

		// Collect what is still in flight, then hold start low again so that any
		// stray result can show up before the verdict.
		pause_input(1);
		while (pending_items != 0)
			@(negedge clk);
		pause_input(4);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
